[design/scsa_pkg.sv]
// Shared types, constants and helper functions of the size class slab allocator.
package scsa_pkg;

   localparam int MAX_SLABS       = 256;
   localparam int SLAB_BYTES      = 65536;
   localparam int NUM_CLASSES     = 6;
   localparam int MIN_CLASS_BYTES = 256;
   localparam int MAX_REQ_BYTES   = MIN_CLASS_BYTES << (NUM_CLASSES - 1);
   localparam int SLOTS_MAX       = SLAB_BYTES / MIN_CLASS_BYTES;
   localparam int DEFAULT_CAP     = 16 * 1024 * 1024;

   localparam int CLS_W   = 3;
   localparam int SLAB_W  = 8;
   localparam int SLOT_W  = 8;
   localparam int ID_W    = SLAB_W + SLOT_W;
   localparam int CNT_W   = SLAB_W + 1;
   localparam int REQ_W   = 16;
   localparam int SIZE_W  = 14;
   localparam int CAP_W   = 25;
   localparam int LIVE_W  = 17;
   localparam int SLOTS_W = SLOT_W + 1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_NO_MEM   = 2'd2,
      ST_FREE_IGN = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type          op;
      logic                bad_size;
      logic [CLS_W-1:0]    cls;
      logic [SLAB_W-1:0]   slab;
      logic [SLOT_W-1:0]   slot;
   } cmd_type;

   function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
      logic [31:0] b;
      b = 32'(MIN_CLASS_BYTES) << c;
      return b[SIZE_W-1:0];
   endfunction

   function automatic logic [SLOTS_W-1:0] class_slots(input logic [CLS_W-1:0] c);
      logic [31:0] n;
      n = 32'(SLOTS_MAX) >> c;
      if (n == 32'd0) begin
         n = 32'd1;
      end
      return n[SLOTS_W-1:0];
   endfunction

endpackage

[design/size_class_slab_allocator.sv]
// Top level of the size class slab allocator: front end, command queue and back end.
// A command passes from the queue through the back end sequencer states S_IDLE and S_EXEC, and S_POP
// for a list pop or S_FREE for a free, into the result register; the sequencer uses registered reads
// of the link, class and busy memories and takes no new command while a result waits.
// The front queue holds two commands, so commands are taken while a result waits.
// Reset clears all control state at once; the memories need no clearing pass.
module size_class_slab_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [scsa_pkg::REQ_W-1:0]      req_request_bytes,
   input  logic [scsa_pkg::SLAB_W-1:0]     req_free_slab_index,
   input  logic [scsa_pkg::SLOT_W-1:0]     req_free_slot_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [scsa_pkg::CLS_W-1:0]      rsp_class_index,
   output logic [scsa_pkg::SLAB_W-1:0]     rsp_slab_index,
   output logic [scsa_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [scsa_pkg::SIZE_W-1:0]     rsp_slot_capacity,
   output logic [scsa_pkg::CAP_W-1:0]      rsp_reserved_total,
   output logic [scsa_pkg::LIVE_W-1:0]     rsp_live_total,
   output logic [scsa_pkg::CAP_W-1:0]      rsp_inuse_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scsa_pkg::CAP_W-1:0]      csr_wdata
);

   logic               q_valid;
   logic               q_pop;
   scsa_pkg::cmd_type  q_cmd;

   assign csr_ready = 1'b1;

   scsa_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_request_bytes   (req_request_bytes),
      .req_free_slab_index (req_free_slab_index),
      .req_free_slot_index (req_free_slot_index),
      .q_valid             (q_valid),
      .q_cmd               (q_cmd),
      .q_pop               (q_pop)
   );

   scsa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid && csr_ready),
      .csr_wdata          (csr_wdata),
      .q_valid            (q_valid),
      .q_cmd              (q_cmd),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_class_index    (rsp_class_index),
      .rsp_slab_index     (rsp_slab_index),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_slot_capacity  (rsp_slot_capacity),
      .rsp_reserved_total (rsp_reserved_total),
      .rsp_live_total     (rsp_live_total),
      .rsp_inuse_total    (rsp_inuse_total)
   );

endmodule

[design/scsa_front.sv]
// Front end: accepts commands, maps byte counts to classes and queues them.
module scsa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [scsa_pkg::REQ_W-1:0]      req_request_bytes,
   input  logic [scsa_pkg::SLAB_W-1:0]     req_free_slab_index,
   input  logic [scsa_pkg::SLOT_W-1:0]     req_free_slot_index,
   output logic                            q_valid,
   output scsa_pkg::cmd_type               q_cmd,
   input  logic                            q_pop
);

   scsa_pkg::cmd_type    entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   scsa_pkg::cmd_type    cmd_new;
   logic                 push;

   always_comb begin
      logic [scsa_pkg::CLS_W-1:0] found;
      found = '0;
      for (int c = scsa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         if ({3'b000, req_request_bytes} <=
             {5'b00000, scsa_pkg::class_bytes(scsa_pkg::CLS_W'(c))}) begin
            found = scsa_pkg::CLS_W'(c);
         end
      end
      cmd_new.op   = scsa_pkg::opcode_type'(req_opcode);
      cmd_new.slab = req_free_slab_index;
      cmd_new.slot = req_free_slot_index;
      cmd_new.bad_size = (req_request_bytes == '0) ||
                         (32'(req_request_bytes) > 32'(scsa_pkg::MAX_REQ_BYTES));
      // Free commands and rejected sizes carry class zero.
      cmd_new.cls = (cmd_new.bad_size || req_opcode) ? '0 : found;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[design/scsa_back.sv]
// Back end: free lists, slab carving, slot busy tracking and the result register.
module scsa_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [scsa_pkg::CAP_W-1:0]      csr_wdata,
   input  logic                            q_valid,
   input  scsa_pkg::cmd_type               q_cmd,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [scsa_pkg::CLS_W-1:0]      rsp_class_index,
   output logic [scsa_pkg::SLAB_W-1:0]     rsp_slab_index,
   output logic [scsa_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [scsa_pkg::SIZE_W-1:0]     rsp_slot_capacity,
   output logic [scsa_pkg::CAP_W-1:0]      rsp_reserved_total,
   output logic [scsa_pkg::LIVE_W-1:0]     rsp_live_total,
   output logic [scsa_pkg::CAP_W-1:0]      rsp_inuse_total
);

   localparam int NC = scsa_pkg::NUM_CLASSES;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP, S_FREE} state_type;

   state_type                       state_ff, state_in;
   scsa_pkg::cmd_type               cmd_ff, cmd_in;
   logic [scsa_pkg::ID_W-1:0]       head_ff [NC];
   logic [scsa_pkg::ID_W-1:0]       head_in [NC];
   logic                            head_vld_ff [NC];
   logic                            head_vld_in [NC];
   logic [scsa_pkg::SLAB_W-1:0]     fresh_slab_ff [NC];
   logic [scsa_pkg::SLAB_W-1:0]     fresh_slab_in [NC];
   logic [scsa_pkg::SLOT_W-1:0]     fresh_cnt_ff [NC];
   logic [scsa_pkg::SLOT_W-1:0]     fresh_cnt_in [NC];
   logic [scsa_pkg::CNT_W-1:0]      slab_count_ff, slab_count_in;
   logic [scsa_pkg::CAP_W-1:0]      reserved_ff, reserved_in;
   logic [scsa_pkg::LIVE_W-1:0]     live_ff, live_in;
   logic [scsa_pkg::CAP_W-1:0]      inuse_ff, inuse_in;
   logic [scsa_pkg::CAP_W-1:0]      cap_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [scsa_pkg::CLS_W-1:0]      rsp_cls_ff, rsp_cls_in;
   logic [scsa_pkg::SLAB_W-1:0]     rsp_slab_ff, rsp_slab_in;
   logic [scsa_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [scsa_pkg::SIZE_W-1:0]     rsp_cap_ff, rsp_cap_in;
   logic [scsa_pkg::CAP_W-1:0]      rsp_res_ff, rsp_res_in;
   logic [scsa_pkg::LIVE_W-1:0]     rsp_live_ff, rsp_live_in;
   logic [scsa_pkg::CAP_W-1:0]      rsp_inuse_ff, rsp_inuse_in;

   // Memories with registered read data.
   logic [scsa_pkg::CLS_W-1:0]      class_mem [scsa_pkg::MAX_SLABS];
   logic [scsa_pkg::ID_W:0]         link_mem [1 << scsa_pkg::ID_W];
   logic                            busy_mem [1 << scsa_pkg::ID_W];
   logic [scsa_pkg::CLS_W-1:0]      cls_rd_ff;
   logic [scsa_pkg::ID_W:0]         link_rd_ff;
   logic                            busy_rd_ff;

   logic                            class_we, link_we, busy_we, busy_wd;
   logic [scsa_pkg::SLAB_W-1:0]     class_wa;
   logic [scsa_pkg::CLS_W-1:0]      class_wd;
   logic [scsa_pkg::ID_W-1:0]       link_wa, busy_wa;
   logic [scsa_pkg::ID_W:0]         link_wd;
   logic [scsa_pkg::ID_W-1:0]       free_id;
   logic [scsa_pkg::CAP_W-1:0]      eff_cap;

   assign free_id = {cmd_ff.slab, cmd_ff.slot};
   assign eff_cap = (cap_ff == '0) ? scsa_pkg::CAP_W'(scsa_pkg::DEFAULT_CAP) : cap_ff;

   always_comb begin
      logic                           emit, grant;
      scsa_pkg::status_type           e_status;
      logic [scsa_pkg::CLS_W-1:0]     c, k;
      logic [scsa_pkg::ID_W-1:0]      gid;
      logic [scsa_pkg::SLOT_W-1:0]    top;
      logic                           k_ok, fresh_hit, ok;
      logic [scsa_pkg::CAP_W:0]       need_sum;

      emit      = 1'b0;
      grant     = 1'b0;
      e_status  = scsa_pkg::ST_OK;
      c         = cmd_ff.cls;
      k         = cls_rd_ff;
      gid       = '0;
      top       = '0;
      k_ok      = 1'b0;
      fresh_hit = 1'b0;
      ok        = 1'b0;
      need_sum  = {1'b0, reserved_ff} + (scsa_pkg::CAP_W + 1)'(scsa_pkg::SLAB_BYTES);

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      head_in       = head_ff;
      head_vld_in   = head_vld_ff;
      fresh_slab_in = fresh_slab_ff;
      fresh_cnt_in  = fresh_cnt_ff;
      slab_count_in = slab_count_ff;
      reserved_in   = reserved_ff;
      live_in       = live_ff;
      inuse_in      = inuse_ff;
      q_pop         = 1'b0;
      class_we = 1'b0; class_wa = cmd_ff.slab[scsa_pkg::SLAB_W-1:0]; class_wd = c;
      link_we  = 1'b0; link_wa  = free_id; link_wd = '0;
      busy_we  = 1'b0; busy_wa  = free_id; busy_wd = 1'b0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_cls_in    = rsp_cls_ff;
      rsp_slab_in   = rsp_slab_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cap_in    = rsp_cap_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_inuse_in  = rsp_inuse_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff.op == scsa_pkg::OP_ALLOC) begin
               if (cmd_ff.bad_size) begin
                  emit     = 1'b1;
                  e_status = scsa_pkg::ST_BAD_SIZE;
               end else if (head_vld_ff[c]) begin
                  // The link read for the list head is under way.
                  state_in = S_POP;
               end else if (fresh_cnt_ff[c] != '0) begin
                  // Untouched slots of the newest slab leave in descending order.
                  top             = fresh_cnt_ff[c] - 1'b1;
                  gid             = {fresh_slab_ff[c], top};
                  fresh_cnt_in[c] = top;
                  grant           = 1'b1;
               end else if ((slab_count_ff < scsa_pkg::CNT_W'(scsa_pkg::MAX_SLABS)) &&
                            (need_sum <= {1'b0, eff_cap})) begin
                  top              = scsa_pkg::SLOT_W'(scsa_pkg::class_slots(c) - 1'b1);
                  gid              = {slab_count_ff[scsa_pkg::SLAB_W-1:0], top};
                  class_we         = 1'b1;
                  class_wa         = slab_count_ff[scsa_pkg::SLAB_W-1:0];
                  fresh_slab_in[c] = slab_count_ff[scsa_pkg::SLAB_W-1:0];
                  fresh_cnt_in[c]  = top;
                  slab_count_in    = slab_count_ff + 1'b1;
                  reserved_in      = need_sum[scsa_pkg::CAP_W-1:0];
                  grant            = 1'b1;
               end else begin
                  emit     = 1'b1;
                  e_status = scsa_pkg::ST_NO_MEM;
               end
            end else begin
               if ({1'b0, cmd_ff.slab} < slab_count_ff) begin
                  state_in = S_FREE;
               end else begin
                  emit     = 1'b1;
                  e_status = scsa_pkg::ST_FREE_IGN;
               end
            end
         end
         S_POP: begin
            gid            = head_ff[c];
            head_in[c]     = link_rd_ff[scsa_pkg::ID_W-1:0];
            head_vld_in[c] = link_rd_ff[scsa_pkg::ID_W];
            grant          = 1'b1;
         end
         S_FREE: begin
            k_ok = (32'(k) < 32'(NC));
            if (k_ok) begin
               // A slot still in the fresh region was never handed out.
               fresh_hit = (cmd_ff.slab == fresh_slab_ff[k]) &&
                           (cmd_ff.slot < fresh_cnt_ff[k]);
               ok = ({1'b0, cmd_ff.slot} < scsa_pkg::class_slots(k)) &&
                    busy_rd_ff && !fresh_hit;
            end
            emit = 1'b1;
            if (ok) begin
               busy_we        = 1'b1;
               busy_wd        = 1'b0;
               link_we        = 1'b1;
               link_wd        = {head_vld_ff[k], head_ff[k]};
               head_in[k]     = free_id;
               head_vld_in[k] = 1'b1;
               live_in        = live_ff - 1'b1;
               inuse_in       = inuse_ff - scsa_pkg::CAP_W'(scsa_pkg::class_bytes(k));
               e_status       = scsa_pkg::ST_OK;
            end else begin
               e_status = scsa_pkg::ST_FREE_IGN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (grant) begin
         busy_we  = 1'b1;
         busy_wa  = gid;
         busy_wd  = 1'b1;
         live_in  = live_ff + 1'b1;
         inuse_in = inuse_ff + scsa_pkg::CAP_W'(scsa_pkg::class_bytes(c));
         emit     = 1'b1;
      end

      if (emit) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = e_status;
         rsp_cls_in    = '0;
         rsp_slab_in   = '0;
         rsp_slot_in   = '0;
         rsp_cap_in    = '0;
         if (grant) begin
            rsp_cls_in  = c;
            rsp_slab_in = gid[scsa_pkg::ID_W-1:scsa_pkg::SLOT_W];
            rsp_slot_in = gid[scsa_pkg::SLOT_W-1:0];
            rsp_cap_in  = scsa_pkg::class_bytes(c);
         end else if (e_status == scsa_pkg::ST_NO_MEM) begin
            rsp_cls_in = c;
         end else if (ok) begin
            rsp_cls_in  = k;
            rsp_slab_in = cmd_ff.slab;
            rsp_slot_in = cmd_ff.slot;
         end
         rsp_res_in   = reserved_in;
         rsp_live_in  = live_in;
         rsp_inuse_in = inuse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slab_count_ff <= '0;
         reserved_ff   <= '0;
         live_ff       <= '0;
         inuse_ff      <= '0;
         cap_ff        <= scsa_pkg::CAP_W'(scsa_pkg::DEFAULT_CAP);
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            head_vld_ff[i]  <= 1'b0;
            fresh_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         slab_count_ff <= slab_count_in;
         reserved_ff   <= reserved_in;
         live_ff       <= live_in;
         inuse_ff      <= inuse_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            cap_ff <= csr_wdata;
         end
         head_vld_ff  <= head_vld_in;
         fresh_cnt_ff <= fresh_cnt_in;
      end
      cmd_ff        <= cmd_in;
      head_ff       <= head_in;
      fresh_slab_ff <= fresh_slab_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_slab_ff   <= rsp_slab_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cap_ff    <= rsp_cap_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_inuse_ff  <= rsp_inuse_in;
   end

   always_ff @(posedge clock) begin
      if (class_we) begin
         class_mem[class_wa] <= class_wd;
      end
      cls_rd_ff <= class_mem[cmd_ff.slab];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[head_ff[cmd_ff.cls]];
   end

   always_ff @(posedge clock) begin
      if (busy_we) begin
         busy_mem[busy_wa] <= busy_wd;
      end
      busy_rd_ff <= busy_mem[free_id];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_class_index    = rsp_cls_ff;
   assign rsp_slab_index     = rsp_slab_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_slot_capacity  = rsp_cap_ff;
   assign rsp_reserved_total = rsp_res_ff;
   assign rsp_live_total     = rsp_live_ff;
   assign rsp_inuse_total    = rsp_inuse_ff;

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result register filled while a command is at work");

   a_slab_limit: assert property (@(posedge clock) disable iff (reset)
      slab_count_ff <= scsa_pkg::CNT_W'(scsa_pkg::MAX_SLABS))
      else $error("slab count beyond the slab limit");

   a_reserved_tracks: assert property (@(posedge clock) disable iff (reset)
      reserved_ff == scsa_pkg::CAP_W'(32'(slab_count_ff) * 32'(scsa_pkg::SLAB_BYTES)))
      else $error("reserved bytes out of step with the slab count");

   a_live_inuse: assert property (@(posedge clock) disable iff (reset)
      (live_ff == '0) |-> (inuse_ff == '0))
      else $error("in-use bytes without live slots");

   a_pop_from_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_EXEC))
      else $error("queue popped without starting a command");

endmodule
